FILE: sv/smt_pkg.sv
`default_nettype none
package smt_pkg;

   localparam int COUNT_W = 5;

   // operation codes
   localparam logic [2:0] FUNC_SUB       = 3'd0;
   localparam logic [2:0] FUNC_UNSUB     = 3'd1;
   localparam logic [2:0] FUNC_UNSUB_ALL = 3'd2;
   localparam logic [2:0] FUNC_LOOKUP    = 3'd3;
   localparam logic [2:0] FUNC_CLEAR_NTF = 3'd4;
   localparam logic [2:0] FUNC_CLEAR     = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DUP       = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // notification codes
   localparam logic [1:0] NTF_NONE  = 2'd0;
   localparam logic [1:0] NTF_SUB   = 2'd1;
   localparam logic [1:0] NTF_UNSUB = 2'd2;

   typedef logic [47:0] pair_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] mbox_id;
      logic [15:0] type_id;
      logic [15:0] state_id;
      logic [15:0] sink_id;
      logic [31:0] handler_id;
      logic        thread_safe;
      logic        kind_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        handler_id_res;
      logic               thread_safe_res;
      logic               kind_flag_res;
      logic [1:0]         notify;
      logic [31:0]        notify_mbox;
      logic [15:0]        notify_type;
      logic [15:0]        notify_sink;
      logic [COUNT_W-1:0] entry_count;
      logic               last;
   } rsp_type;

   // one stored subscription; flags bit 0 thread_safe, bit 1 kind_flag
   typedef struct packed {
      logic [31:0] mbox;
      logic [15:0] mtype;
      logic [15:0] state;
      logic [15:0] sink;
      logic [31:0] handler;
      logic [1:0]  flags;
   } entry_type;

   // compare results for one entry
   typedef struct packed {
      logic key_hit;
      logic pair_hit;
      logic above_prev;
      logic below_best;
   } scan_hit_type;

endpackage
`default_nettype wire

FILE: sv/subscription_match_table_core.sv
// Channel   Ports                          Direction   Beat
// request   req_valid req_stall req_data   in          one operation
// response  rsp_valid rsp_stall rsp_data   out         one result, last marks the end
//
// Every operation on a non-empty table scans it once, one entry at a time
// through a single read port and one compare unit.
// Clear with notify repeats the scan once per distinct pair, plus one round.
// Synchronous reset empties the table; no clearing pass is needed.
// A result waits in the output register while rsp_stall is high; the next
// request is taken as soon as the sequencer is idle.
`default_nettype none
module subscription_match_table_core
   import smt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_EV   = 3'd2;
   localparam logic [2:0] S_END  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in, w_ff, w_in, cnt_ff, cnt_in;
   req_type       req_ff, req_in;
   logic          key_found_ff, key_found_in, pair_found_ff, pair_found_in;
   logic          pair_multi_ff, pair_multi_in;
   logic [15:0]   key_sink_ff, key_sink_in, pair_sink_ff, pair_sink_in;
   logic [31:0]   key_hdl_ff, key_hdl_in;
   logic [1:0]    key_flags_ff, key_flags_in;
   logic          best_v_ff, best_v_in, have_prev_ff, have_prev_in;
   pair_type      best_ff, best_in, prev_ff, prev_in, pend_ff, pend_in;
   logic [15:0]   best_sink_ff, best_sink_in, pend_sink_ff, pend_sink_in;
   logic          pend_v_ff, pend_v_in;
   rsp_type       res_ff, res_in, rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data, rd_data;
   scan_hit_type  hit;
   logic          slot_free, removing, cand;

   smt_ram #(.WIDTH($bits(entry_type)), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   smt_scan u_scan (
      .entry     (rd_data),
      .req       (req_ff),
      .prev_pair (prev_ff),
      .best_pair (best_ff),
      .hit       (hit)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      w_in          = w_ff;
      cnt_in        = cnt_ff;
      req_in        = req_ff;
      key_found_in  = key_found_ff;
      pair_found_in = pair_found_ff;
      pair_multi_in = pair_multi_ff;
      key_sink_in   = key_sink_ff;
      key_hdl_in    = key_hdl_ff;
      key_flags_in  = key_flags_ff;
      pair_sink_in  = pair_sink_ff;
      best_v_in     = best_v_ff;
      best_in       = best_ff;
      best_sink_in  = best_sink_ff;
      have_prev_in  = have_prev_ff;
      prev_in       = prev_ff;
      pend_v_in     = pend_v_ff;
      pend_in       = pend_ff;
      pend_sink_in  = pend_sink_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      wr_en         = 1'b0;
      wr_addr       = w_ff[AW-1:0];
      wr_data       = rd_data;
      removing      = 1'b0;
      cand          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               idx_in        = '0;
               w_in          = '0;
               key_found_in  = 1'b0;
               pair_found_in = 1'b0;
               pair_multi_in = 1'b0;
               best_v_in     = 1'b0;
               have_prev_in  = 1'b0;
               pend_v_in     = 1'b0;
               state_in      = (cnt_ff == '0) ? S_END : S_RD;
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            // accumulate key and pair matches
            if (hit.key_hit && !key_found_ff) begin
               key_found_in = 1'b1;
               key_sink_in  = rd_data.sink;
               key_hdl_in   = rd_data.handler;
               key_flags_in = rd_data.flags;
            end
            if (hit.pair_hit) begin
               if (!pair_found_ff) begin
                  pair_sink_in = rd_data.sink;
               end
               pair_found_in = 1'b1;
               pair_multi_in = pair_multi_ff || pair_found_ff;
            end
            // compact the table: keep entries that are not removed
            if (req_ff.func == FUNC_UNSUB || req_ff.func == FUNC_UNSUB_ALL) begin
               removing = (req_ff.func == FUNC_UNSUB) ? hit.key_hit : hit.pair_hit;
               if (!removing) begin
                  wr_en = 1'b1;
                  w_in  = w_ff + 1'b1;
               end
            end
            // track smallest pair above the last one reported
            cand = (!have_prev_ff || hit.above_prev) && (!best_v_ff || hit.below_best);
            if (cand) begin
               best_v_in    = 1'b1;
               best_in      = {rd_data.mbox, rd_data.mtype};
               best_sink_in = rd_data.sink;
            end
            if (idx_ff + 1'b1 == cnt_ff) begin
               state_in = S_END;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_END: begin
            res_in        = '0;
            res_in.last   = 1'b1;
            state_in      = S_EMIT;
            unique case (req_ff.func)
               FUNC_SUB: begin
                  if (key_found_ff) begin
                     res_in.status = ST_DUP;
                  end else if (cnt_ff == CW'(TABLE_DEPTH)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     wr_en           = 1'b1;
                     wr_addr         = cnt_ff[AW-1:0];
                     wr_data.mbox    = req_ff.mbox_id;
                     wr_data.mtype   = req_ff.type_id;
                     wr_data.state   = req_ff.state_id;
                     wr_data.sink    = req_ff.sink_id;
                     wr_data.handler = req_ff.handler_id;
                     wr_data.flags   = {req_ff.kind_flag, req_ff.thread_safe};
                     cnt_in          = cnt_ff + 1'b1;
                     if (!pair_found_ff) begin
                        res_in.notify      = NTF_SUB;
                        res_in.notify_mbox = req_ff.mbox_id;
                        res_in.notify_type = req_ff.type_id;
                        res_in.notify_sink = req_ff.sink_id;
                     end
                  end
               end
               FUNC_UNSUB: begin
                  if (!key_found_ff) begin
                     res_in.status = ST_NOT_FOUND;
                  end else begin
                     cnt_in = w_ff;
                     if (!pair_multi_ff) begin
                        res_in.notify      = NTF_UNSUB;
                        res_in.notify_mbox = req_ff.mbox_id;
                        res_in.notify_type = req_ff.type_id;
                        res_in.notify_sink = key_sink_ff;
                     end
                  end
               end
               FUNC_UNSUB_ALL: begin
                  if (!pair_found_ff) begin
                     res_in.status = ST_NOT_FOUND;
                  end else begin
                     cnt_in             = w_ff;
                     res_in.notify      = NTF_UNSUB;
                     res_in.notify_mbox = req_ff.mbox_id;
                     res_in.notify_type = req_ff.type_id;
                     res_in.notify_sink = pair_sink_ff;
                  end
               end
               FUNC_LOOKUP: begin
                  if (!key_found_ff) begin
                     res_in.status = ST_NOT_FOUND;
                  end else begin
                     res_in.handler_id_res  = key_hdl_ff;
                     res_in.thread_safe_res = key_flags_ff[0];
                     res_in.kind_flag_res   = key_flags_ff[1];
                  end
               end
               FUNC_CLEAR_NTF: begin
                  // hold one pair back so the final beat carries last
                  if (pend_v_ff) begin
                     res_in.notify      = NTF_UNSUB;
                     res_in.notify_mbox = pend_ff[47:16];
                     res_in.notify_type = pend_ff[15:0];
                     res_in.notify_sink = pend_sink_ff;
                  end
                  if (best_v_ff) begin
                     res_in.last  = 1'b0;
                     pend_v_in    = 1'b1;
                     pend_in      = best_ff;
                     pend_sink_in = best_sink_ff;
                     prev_in      = best_ff;
                     have_prev_in = 1'b1;
                     best_v_in    = 1'b0;
                     idx_in       = '0;
                     if (!pend_v_ff) begin
                        state_in = S_RD;
                     end
                  end else begin
                     cnt_in = '0;
                  end
               end
               FUNC_CLEAR: begin
                  cnt_in = '0;
               end
               default: begin
               end
            endcase
            // the table counts as empty on every beat of a clear with notify
            if (state_in == S_EMIT) begin
               res_in.entry_count = (req_ff.func == FUNC_CLEAR_NTF) ? '0 : COUNT_W'(cnt_in);
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = res_ff.last ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      w_ff          <= w_in;
      req_ff        <= req_in;
      key_found_ff  <= key_found_in;
      pair_found_ff <= pair_found_in;
      pair_multi_ff <= pair_multi_in;
      key_sink_ff   <= key_sink_in;
      key_hdl_ff    <= key_hdl_in;
      key_flags_ff  <= key_flags_in;
      pair_sink_ff  <= pair_sink_in;
      best_v_ff     <= best_v_in;
      best_ff       <= best_in;
      best_sink_ff  <= best_sink_in;
      have_prev_ff  <= have_prev_in;
      prev_ff       <= prev_in;
      pend_v_ff     <= pend_v_in;
      pend_ff       <= pend_in;
      pend_sink_ff  <= pend_sink_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

endmodule
`default_nettype wire

FILE: sv/smt_ram.sv
`default_nettype none
module smt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: sv/smt_scan.sv
`default_nettype none
module smt_scan
   import smt_pkg::*;
(
   input  wire entry_type    entry,
   input  wire req_type      req,
   input  wire pair_type     prev_pair,
   input  wire pair_type     best_pair,
   output scan_hit_type      hit
);

   pair_type entry_pair;

   // compare one entry against the request key and the running order bounds
   always_comb begin
      entry_pair     = {entry.mbox, entry.mtype};
      hit.pair_hit   = (entry.mbox == req.mbox_id) && (entry.mtype == req.type_id);
      hit.key_hit    = hit.pair_hit && (entry.state == req.state_id);
      hit.above_prev = entry_pair > prev_pair;
      hit.below_best = entry_pair < best_pair;
   end

endmodule
`default_nettype wire

FILE: sv/smt_checker.sv
`default_nettype none
module smt_checker
   import smt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // reset leaves the block idle and empty of results
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("not idle after reset");

   // only clear with notify gives non-final beats, each an unsubscribe
   a_mid_unsub: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.notify == NTF_UNSUB
         && rsp_data.entry_count == '0)
      else $error("non-final beat is not an unsubscribe");

   // a failed operation never notifies nor returns a handler
   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.notify == NTF_NONE
         && rsp_data.handler_id_res == '0)
      else $error("failed operation produced data");

endmodule

bind subscription_match_table_core smt_checker u_smt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: tb/subscription_match_table_core_tb.sv
`default_nettype none
module subscription_match_table_core_tb
   import smt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int FUNC_UNUSED = 6;
   localparam longint CYCLE_LIMIT = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   subscription_match_table_core #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // shadow copy of the subscription table
   entry_type   shadow_tab[DEPTH];
   int unsigned shadow_used;
   rsp_type     pending_rsp[$];
   int          fail_count = 0;
   int          rsp_count = 0;
   int          notify_count = 0;
   longint      cycle_count = 0;
   bit          quiet = 1'b0;

   function automatic rsp_type plain_rsp(logic [1:0] status);
      rsp_type r;
      r = '0;
      r.status = status;
      r.entry_count = shadow_used[COUNT_W-1:0];
      r.last = 1'b1;
      return r;
   endfunction

   function automatic int find_key(logic [31:0] mb, logic [15:0] ty, logic [15:0] st);
      for (int i = 0; i < shadow_used; i++)
         if (shadow_tab[i].mbox == mb && shadow_tab[i].mtype == ty &&
             shadow_tab[i].state == st) return i;
      return -1;
   endfunction

   function automatic int find_pair(pair_type p);
      for (int i = 0; i < shadow_used; i++)
         if ({shadow_tab[i].mbox, shadow_tab[i].mtype} == p) return i;
      return -1;
   endfunction

   // advance the shadow table by one operation and queue its results
   task automatic predict_table_op(req_type q);
      pair_type  p;
      int        pos;
      int        j;
      int        best;
      logic [15:0] s;
      rsp_type   r;
      pair_type  prev;
      pair_type  bp;
      bit        have_prev;
      int unsigned total;
      p = {q.mbox_id, q.type_id};
      case (q.func)
         FUNC_SUB: begin
            if (find_key(q.mbox_id, q.type_id, q.state_id) >= 0)
               pending_rsp.push_back(plain_rsp(ST_DUP));
            else if (shadow_used >= DEPTH)
               pending_rsp.push_back(plain_rsp(ST_FULL));
            else begin
               pos = find_pair(p);
               shadow_tab[shadow_used] = '{q.mbox_id, q.type_id, q.state_id, q.sink_id,
                                           q.handler_id, {q.kind_flag, q.thread_safe}};
               shadow_used++;
               r = plain_rsp(ST_OK);
               if (pos < 0) begin
                  r.notify = NTF_SUB;
                  r.notify_mbox = q.mbox_id;
                  r.notify_type = q.type_id;
                  r.notify_sink = q.sink_id;
               end
               pending_rsp.push_back(r);
            end
         end
         FUNC_UNSUB: begin
            pos = find_key(q.mbox_id, q.type_id, q.state_id);
            if (pos < 0)
               pending_rsp.push_back(plain_rsp(ST_NOT_FOUND));
            else begin
               s = shadow_tab[pos].sink;
               for (int i = pos; i + 1 < shadow_used; i++) shadow_tab[i] = shadow_tab[i+1];
               shadow_used--;
               r = plain_rsp(ST_OK);
               if (find_pair(p) < 0) begin
                  r.notify = NTF_UNSUB;
                  r.notify_mbox = q.mbox_id;
                  r.notify_type = q.type_id;
                  r.notify_sink = s;
               end
               pending_rsp.push_back(r);
            end
         end
         FUNC_UNSUB_ALL: begin
            pos = find_pair(p);
            if (pos < 0)
               pending_rsp.push_back(plain_rsp(ST_NOT_FOUND));
            else begin
               s = shadow_tab[pos].sink;
               j = 0;
               for (int i = 0; i < shadow_used; i++)
                  if ({shadow_tab[i].mbox, shadow_tab[i].mtype} != p) begin
                     shadow_tab[j] = shadow_tab[i];
                     j++;
                  end
               shadow_used = j;
               r = plain_rsp(ST_OK);
               r.notify = NTF_UNSUB;
               r.notify_mbox = q.mbox_id;
               r.notify_type = q.type_id;
               r.notify_sink = s;
               pending_rsp.push_back(r);
            end
         end
         FUNC_LOOKUP: begin
            pos = find_key(q.mbox_id, q.type_id, q.state_id);
            if (pos < 0)
               pending_rsp.push_back(plain_rsp(ST_NOT_FOUND));
            else begin
               r = plain_rsp(ST_OK);
               r.handler_id_res = shadow_tab[pos].handler;
               r.thread_safe_res = shadow_tab[pos].flags[0];
               r.kind_flag_res = shadow_tab[pos].flags[1];
               pending_rsp.push_back(r);
            end
         end
         FUNC_CLEAR_NTF: begin
            total = shadow_used;
            if (total == 0)
               pending_rsp.push_back(plain_rsp(ST_OK));
            else begin
               shadow_used = 0;
               have_prev = 0;
               prev = '0;
               // emit pairs in ascending order, earliest entry's sink
               forever begin
                  best = -1;
                  bp = '0;
                  for (int i = 0; i < total; i++) begin
                     if (have_prev && {shadow_tab[i].mbox, shadow_tab[i].mtype} <= prev)
                        continue;
                     if (best < 0 || {shadow_tab[i].mbox, shadow_tab[i].mtype} < bp) begin
                        best = i;
                        bp = {shadow_tab[i].mbox, shadow_tab[i].mtype};
                     end
                  end
                  if (best < 0) break;
                  r = plain_rsp(ST_OK);
                  r.last = 1'b0;
                  r.notify = NTF_UNSUB;
                  r.notify_mbox = shadow_tab[best].mbox;
                  r.notify_type = shadow_tab[best].mtype;
                  r.notify_sink = shadow_tab[best].sink;
                  pending_rsp.push_back(r);
                  prev = bp;
                  have_prev = 1;
               end
               pending_rsp[$].last = 1'b1;
            end
         end
         default: begin
            if (q.func == FUNC_CLEAR) shadow_used = 0;
            pending_rsp.push_back(plain_rsp(ST_OK));
         end
      endcase
   endtask

   // compare each result beat with the oldest expectation
   rsp_type exp_r;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         if (pending_rsp.size() == 0) begin
            $error("unexpected result beat %p", rsp_data);
            fail_count <= fail_count + 1;
         end else begin
            exp_r = pending_rsp.pop_front();
            if (exp_r.notify != NTF_NONE) notify_count <= notify_count + 1;
            if (rsp_data !== exp_r) begin
               fail_count <= fail_count + 1;
               if (rsp_data.status !== exp_r.status)
                  $error("status exp %0d got %0d", exp_r.status, rsp_data.status);
               if (rsp_data.handler_id_res !== exp_r.handler_id_res)
                  $error("handler_id_res exp %h got %h", exp_r.handler_id_res,
                         rsp_data.handler_id_res);
               if (rsp_data.thread_safe_res !== exp_r.thread_safe_res)
                  $error("thread_safe_res exp %b got %b", exp_r.thread_safe_res,
                         rsp_data.thread_safe_res);
               if (rsp_data.kind_flag_res !== exp_r.kind_flag_res)
                  $error("kind_flag_res exp %b got %b", exp_r.kind_flag_res,
                         rsp_data.kind_flag_res);
               if (rsp_data.notify !== exp_r.notify)
                  $error("notify exp %0d got %0d", exp_r.notify, rsp_data.notify);
               if (rsp_data.notify_mbox !== exp_r.notify_mbox)
                  $error("notify_mbox exp %h got %h", exp_r.notify_mbox, rsp_data.notify_mbox);
               if (rsp_data.notify_type !== exp_r.notify_type)
                  $error("notify_type exp %h got %h", exp_r.notify_type, rsp_data.notify_type);
               if (rsp_data.notify_sink !== exp_r.notify_sink)
                  $error("notify_sink exp %h got %h", exp_r.notify_sink, rsp_data.notify_sink);
               if (rsp_data.entry_count !== exp_r.entry_count)
                  $error("entry_count exp %0d got %0d", exp_r.entry_count,
                         rsp_data.entry_count);
               if (rsp_data.last !== exp_r.last)
                  $error("last exp %b got %b", exp_r.last, rsp_data.last);
            end
         end
      end
   end

   // random result-side stall bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("subscription_match_table_core: mismatch");
         $finish;
      end
   end

   // hand one request beat to the block, with an optional idle burst first
   task automatic send_op(req_type q, bit allow_gap);
      int gap;
      if (allow_gap && !quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      predict_table_op(q);
      do @(posedge clock); while (req_stall);
   endtask

   // directed row; check, when set, means want must equal the predicted single result
   typedef struct {
      req_type q;
      bit      check;
      rsp_type want;
   } row_type;

   function automatic req_type mk(logic [2:0] f, logic [31:0] mb, logic [15:0] ty,
                                  logic [15:0] st, logic [15:0] sk, logic [31:0] hd,
                                  logic ts, logic hk);
      req_type q;
      q = '{f, mb, ty, st, sk, hd, ts, hk};
      return q;
   endfunction

   function automatic rsp_type want_of(logic [1:0] status, logic [1:0] ntf,
                                       logic [31:0] mb, logic [15:0] ty,
                                       logic [15:0] sk, int cnt);
      rsp_type r;
      r = '0;
      r.status = status;
      r.notify = ntf;
      r.notify_mbox = mb;
      r.notify_type = ty;
      r.notify_sink = sk;
      r.entry_count = cnt[COUNT_W-1:0];
      r.last = 1'b1;
      return r;
   endfunction

   // random request; mode 0 draws from a small key space so hits are common
   function automatic req_type rand_op(int mode);
      req_type q;
      int f;
      f = $urandom_range(0, 99);
      q.func = f < 40 ? FUNC_SUB : f < 55 ? FUNC_UNSUB : f < 63 ? FUNC_UNSUB_ALL :
               f < 88 ? FUNC_LOOKUP : f < 93 ? FUNC_CLEAR_NTF : f < 96 ? FUNC_CLEAR :
               3'($urandom_range(FUNC_UNUSED, 7));
      q.mbox_id = (mode == 0) ? 32'($urandom_range(0, 3)) * 32'h5555_5555 : $urandom;
      q.type_id = (mode == 0) ? 16'($urandom_range(0, 2)) * 16'h7fff : 16'($urandom);
      q.state_id = (mode == 0) ? 16'($urandom_range(0, 2)) * 16'h8001 : 16'($urandom);
      q.sink_id = 16'($urandom);
      q.handler_id = $urandom;
      q.thread_safe = 1'($urandom);
      q.kind_flag = 1'($urandom);
      return q;
   endfunction

   row_type rows[$];
   rsp_type got_want;

   initial begin
      for (int i = 0; i < DEPTH; i++) shadow_tab[i] = '0;
      shadow_used = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      rows.push_back('{mk(FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1,
                       want_of(ST_NOT_FOUND, NTF_NONE, 0, 0, 0, 0)});
      rows.push_back('{mk(FUNC_CLEAR_NTF, 0, 0, 0, 0, 0, 0, 0), 1,
                       want_of(ST_OK, NTF_NONE, 0, 0, 0, 0)});
      rows.push_back('{mk(FUNC_UNSUB, 5, 5, 5, 0, 0, 0, 0), 1,
                       want_of(ST_NOT_FOUND, NTF_NONE, 0, 0, 0, 0)});
      rows.push_back('{mk(FUNC_UNSUB_ALL, 5, 5, 0, 0, 0, 0, 0), 1,
                       want_of(ST_NOT_FOUND, NTF_NONE, 0, 0, 0, 0)});
      rows.push_back('{mk(FUNC_SUB, '1, '1, '1, '1, '1, 1, 1), 1,
                       want_of(ST_OK, NTF_SUB, '1, '1, '1, 1)});
      rows.push_back('{mk(FUNC_SUB, '1, '1, '1, 16'h1234, 0, 0, 0), 1,
                       want_of(ST_DUP, NTF_NONE, 0, 0, 0, 1)});
      rows.push_back('{mk(FUNC_LOOKUP, '1, '1, '1, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(FUNC_SUB, '1, '1, 0, 16'h0042, 32'h0, 0, 1), 0, '0});
      rows.push_back('{mk(FUNC_SUB, 0, 0, 0, 16'h0, 32'hdead_beef, 1, 0), 0, '0});
      rows.push_back('{mk(FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(3'(FUNC_UNUSED), 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(3'd7, '1, '1, '1, '1, '1, 1, 1), 0, '0});
      rows.push_back('{mk(FUNC_UNSUB, '1, '1, '1, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(FUNC_UNSUB, '1, '1, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(FUNC_SUB, 32'h8000_0000, 16'h8000, 1, 7, 1, 0, 0), 0, '0});
      rows.push_back('{mk(FUNC_SUB, 32'h8000_0000, 16'h8000, 2, 8, 2, 1, 1), 0, '0});
      rows.push_back('{mk(FUNC_UNSUB_ALL, 32'h8000_0000, 16'h8000, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(FUNC_SUB, 9, 1, 1, 1, 1, 0, 0), 0, '0});
      rows.push_back('{mk(FUNC_SUB, 3, 2, 1, 2, 2, 0, 0), 0, '0});
      rows.push_back('{mk(FUNC_SUB, 3, 2, 2, 3, 3, 0, 0), 0, '0});
      rows.push_back('{mk(FUNC_CLEAR_NTF, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(FUNC_SUB, 1, 1, 1, 1, 1, 0, 0), 0, '0});
      rows.push_back('{mk(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1,
                       want_of(ST_OK, NTF_NONE, 0, 0, 0, 0)});
      foreach (rows[k]) begin
         send_op(rows[k].q, 1);
         if (rows[k].check) begin
            got_want = pending_rsp[$];
            if (got_want !== rows[k].want) begin
               $error("directed row %0d: table prediction %p, typed %p", k, got_want,
                      rows[k].want);
               fail_count++;
            end
         end
      end

      // fill to the limit, then hit the full case
      for (int i = 0; i <= DEPTH; i++)
         send_op(mk(FUNC_SUB, 32'(i % 5), 16'(i % 3), 16'(i), 16'(i), 32'(i), 0, 1), 1);

      // hold off until the block has drained
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      send_op(mk(FUNC_CLEAR_NTF, 0, 0, 0, 0, 0, 0, 0), 1);

      // random part: mostly tight key space, some wide noise
      for (int n = 0; n < 300; n++) begin
         if (n == 260) quiet = 1'b1;
         send_op(rand_op($urandom_range(0, 9) == 0), 1);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d result beats, %0d notifications, dup/full/absent and both clears",
               rsp_count, notify_count);
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("subscription_match_table_core: match");
      else
         $display("subscription_match_table_core: mismatch");
      $finish;
   end
endmodule
`default_nettype wire
